@@ src/iorb_pkg.sv @@
// Shared types and constants for the interval overlap rebinner.
package iorb_pkg;

   localparam int ACC_W     = 48;
   localparam int CONTENT_W = 32;
   localparam int CMD_W     = 2;
   localparam int CFG_W     = 6;
   localparam int EIDX_W    = 6;
   localparam int BIDX_W    = 5;

   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   localparam logic [CMD_W-1:0] CMD_LOAD_EDGE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACCUMULATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READOUT    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd3;

   // Per-cycle commands from the sequencer to every bin cell.
   typedef struct packed {
      logic start;   // latch overlap, reset divider and product
      logic step;    // one quotient bit and one product bit
      logic commit;  // add finished product into the accumulator
      logic clear;   // zero accumulator and saturated flag
      logic rotate;  // take accumulator from the next cell in the ring
   } cell_ctl_type;

endpackage

@@ src/iorb_cell.sv @@
// One target bin: edges, bit-serial divide and multiply, saturating accumulator.
module iorb_cell #(
   parameter int IDX       = 0,
   parameter int EDGE_BITS = 20,
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  iorb_pkg::cell_ctl_type         ctl,
   input  logic                           edge_we,
   input  logic [iorb_pkg::EIDX_W-1:0]    edge_index,
   input  logic [EDGE_BITS-1:0]           edge_value,
   input  logic                           bin_en,
   input  logic [EDGE_BITS-1:0]           src_low,
   input  logic [EDGE_BITS-1:0]           src_high,
   input  logic [EDGE_BITS-1:0]           src_width,
   input  logic [iorb_pkg::CONTENT_W-1:0] src_content,
   input  logic [iorb_pkg::ACC_W-1:0]     rot_acc_in,
   input  logic                           rot_sat_in,
   output logic [iorb_pkg::ACC_W-1:0]     acc_out,
   output logic                           sat_out
);
   import iorb_pkg::*;

   localparam int PW = CONTENT_W + FRAC_BITS + 1;

   logic [EDGE_BITS-1:0] lo_edge_ff, hi_edge_ff;
   logic [EDGE_BITS:0]   rem_ff, rem_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic                 hit_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic                 sat_ff;

   logic [EDGE_BITS-1:0] ov_start, ov_stop, ov_len;
   logic                 q_bit;
   logic [EDGE_BITS:0]   rem_sub;
   logic [ACC_W:0]       sum;

   assign ov_start = (lo_edge_ff > src_low)  ? lo_edge_ff : src_low;
   assign ov_stop  = (hi_edge_ff < src_high) ? hi_edge_ff : src_high;
   assign ov_len   = ov_stop - ov_start;

   // Restoring division, quotient MSB first; the product follows bit by bit.
   assign q_bit   = rem_ff >= {1'b0, src_width};
   assign rem_sub = q_bit ? (rem_ff - {1'b0, src_width}) : rem_ff;
   assign rem_in  = {rem_sub[EDGE_BITS-1:0], 1'b0};
   assign prod_in = {prod_ff[PW-2:0], 1'b0} + (q_bit ? PW'(src_content) : '0);

   assign sum = {1'b0, acc_ff} + (ACC_W+1)'(prod_ff[PW-1:FRAC_BITS]);

   always_ff @(posedge clock) begin
      if (edge_we && (int'(edge_index) == IDX)) begin
         lo_edge_ff <= edge_value;
      end
      if (edge_we && (int'(edge_index) == IDX + 1)) begin
         hi_edge_ff <= edge_value;
      end
      if (ctl.start) begin
         rem_ff  <= {1'b0, ov_len};
         prod_ff <= '0;
      end else if (ctl.step) begin
         rem_ff  <= rem_in;
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
         acc_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         if (ctl.start) begin
            hit_ff <= bin_en && (ov_stop > ov_start);
         end
         if (ctl.clear) begin
            acc_ff <= '0;
            sat_ff <= 1'b0;
         end else if (ctl.rotate) begin
            acc_ff <= rot_acc_in;
            sat_ff <= rot_sat_in;
         end else if (ctl.commit && hit_ff) begin
            if (sum >= {1'b0, ACC_MAX}) begin
               acc_ff <= ACC_MAX;
               sat_ff <= 1'b1;
            end else begin
               acc_ff <= sum[ACC_W-1:0];
            end
         end
      end
   end

   assign acc_out = acc_ff;
   assign sat_out = sat_ff;
endmodule

@@ src/interval_overlap_rebinner_core.sv @@
// Top level of the interval overlap rebinner: sequencer, ring of bin cells, output register.
//
// Usage
//   req_* carries one command item per handshake: load an edge, accumulate a
//   source interval, read out the bins, or clear the accumulators.
//   rsp_* carries one item per bin in use on a readout, bin 0 first, with
//   rsp_last on the final one. csr_* writes bins_in_use (clamped to 1..MAX_BINS).
// Timing
//   Edge load and clear complete in idle, at the accept. An accumulate passes
//   from its accept through LOAD, which latches the overlaps, DIV, which holds
//   the FRAC_BITS + 1 divide/multiply steps that every cell runs in parallel,
//   and ADD, then returns to idle before the next accept.
//   A zero or negative width is dropped in idle and sets the error flag.
//   A readout rotates the accumulator ring MAX_BINS times, one bin per cycle
//   while the output register can take it, emitting the bins in use from cell 0;
//   the request side is held until the ring is home, and longer while a full output
//   register waits on rsp_ready. The first bin passes through READ and the output register.
// Reset and stall
//   Reset (synchronous) zeroes accumulators, saturated flags, the error flag and
//   sets bins_in_use to 32. Edges are undefined until loaded. While a bin in use
//   waits at a full output register the ring holds; requests wait until readout ends.
module interval_overlap_rebinner_core #(
   parameter int MAX_BINS  = 32,
   parameter int EDGE_BITS = 20,
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [iorb_pkg::CMD_W-1:0]     req_cmd,
   input  logic [iorb_pkg::EIDX_W-1:0]    req_edge_index,
   input  logic [EDGE_BITS-1:0]           req_edge_value,
   input  logic [EDGE_BITS-1:0]           req_src_low,
   input  logic [EDGE_BITS-1:0]           req_src_high,
   input  logic [iorb_pkg::CONTENT_W-1:0] req_src_content,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [iorb_pkg::BIDX_W-1:0]    rsp_bin_index,
   output logic [iorb_pkg::ACC_W-1:0]     rsp_bin_total,
   output logic                           rsp_saturated,
   output logic                           rsp_width_error,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [iorb_pkg::CFG_W-1:0]     csr_bins_in_use
);
   import iorb_pkg::*;

   localparam int CNT_W  = $clog2(MAX_BINS + 1);
   localparam int STEP_W = $clog2(FRAC_BITS + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOAD = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_ADD  = 5'b01000,
      ST_READ = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [CFG_W-1:0]       bins_ff;
   logic                   werr_ff;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [EDGE_BITS-1:0]   lo_ff, hi_ff, width_ff;
   logic [CONTENT_W-1:0]   content_ff;

   logic                   rsp_valid_ff;
   logic [BIDX_W-1:0]      rsp_bin_index_ff;
   logic [ACC_W-1:0]       rsp_bin_total_ff;
   logic                   rsp_saturated_ff;
   logic                   rsp_width_error_ff;
   logic                   rsp_last_ff;

   logic                   req_fire, rsp_load, can_load, emitting;
   logic [CNT_W-1:0]       bins_n;
   logic [MAX_BINS-1:0]    bin_en;
   cell_ctl_type           ctl;
   logic [ACC_W-1:0]       acc_out [MAX_BINS];
   logic                   sat_out [MAX_BINS];

   // Clamp the register to 1..MAX_BINS.
   always_comb begin
      if (bins_ff == '0) begin
         bins_n = CNT_W'(1);
      end else if (int'(bins_ff) > MAX_BINS) begin
         bins_n = CNT_W'(MAX_BINS);
      end else begin
         bins_n = CNT_W'(bins_ff);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Output register frees when empty or when the current item is taken.
   assign can_load = !rsp_valid_ff || rsp_ready;
   assign emitting = (cnt_ff < bins_n);
   assign rsp_load = (state_ff == ST_READ) && emitting && can_load;

   always_comb begin
      ctl        = '0;
      ctl.start  = (state_ff == ST_LOAD);
      ctl.step   = (state_ff == ST_DIV);
      ctl.commit = (state_ff == ST_ADD);
      ctl.clear  = req_fire && (req_cmd == CMD_CLEAR);
      // Past the bins in use, keep rotating so every cell returns home.
      ctl.rotate = (state_ff == ST_READ) && (emitting ? can_load : 1'b1);
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_cmd == CMD_ACCUMULATE) && (req_src_high > req_src_low)) begin
               state_in = ST_LOAD;
            end else if (req_fire && (req_cmd == CMD_READOUT)) begin
               state_in = ST_READ;
               cnt_in   = '0;
            end
         end
         ST_LOAD: begin
            state_in = ST_DIV;
            step_in  = '0;
         end
         ST_DIV: begin
            if (step_ff == STEP_W'(FRAC_BITS)) begin
               state_in = ST_ADD;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_ADD: begin
            state_in = ST_IDLE;
         end
         ST_READ: begin
            if (ctl.rotate) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(MAX_BINS - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bins_ff      <= CFG_W'(32);
         werr_ff      <= 1'b0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
         if (csr_valid && csr_ready) begin
            bins_ff <= csr_bins_in_use;
         end
         // Drop empty intervals and flag them.
         if (req_fire && (req_cmd == CMD_ACCUMULATE) && !(req_src_high > req_src_low)) begin
            werr_ff <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the interval for the whole accumulate.
   always_ff @(posedge clock) begin
      if (req_fire && (req_cmd == CMD_ACCUMULATE)) begin
         lo_ff      <= req_src_low;
         hi_ff      <= req_src_high;
         width_ff   <= req_src_high - req_src_low;
         content_ff <= req_src_content;
      end
      if (rsp_load) begin
         rsp_bin_index_ff   <= BIDX_W'(cnt_ff);
         rsp_bin_total_ff   <= acc_out[0];
         rsp_saturated_ff   <= sat_out[0];
         rsp_width_error_ff <= werr_ff;
         rsp_last_ff        <= (({1'b0, cnt_ff} + 1'b1) == {1'b0, bins_n});
      end
   end

   genvar b;
   generate
      for (b = 0; b < MAX_BINS; b++) begin : g_cell
         assign bin_en[b] = (CNT_W'(b) < bins_n);
         iorb_cell #(
            .IDX       (b),
            .EDGE_BITS (EDGE_BITS),
            .FRAC_BITS (FRAC_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .edge_we     (req_fire && (req_cmd == CMD_LOAD_EDGE)),
            .edge_index  (req_edge_index),
            .edge_value  (req_edge_value),
            .bin_en      (bin_en[b]),
            .src_low     (lo_ff),
            .src_high    (hi_ff),
            .src_width   (width_ff),
            .src_content (content_ff),
            .rot_acc_in  (acc_out[(b + 1) % MAX_BINS]),
            .rot_sat_in  (sat_out[(b + 1) % MAX_BINS]),
            .acc_out     (acc_out[b]),
            .sat_out     (sat_out[b])
         );
      end
   endgenerate

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bin_index   = rsp_bin_index_ff;
   assign rsp_bin_total   = rsp_bin_total_ff;
   assign rsp_saturated   = rsp_saturated_ff;
   assign rsp_width_error = rsp_width_error_ff;
   assign rsp_last        = rsp_last_ff;

   // A new result item only appears during a readout.
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_READ))
      else $error("result item outside readout");

   // The last flag marks the final bin in use.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_bin_index == BIDX_W'(bins_n - 1'b1)))
      else $error("last flag on wrong bin");

   // The divide counter never runs past its final step.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff <= STEP_W'(FRAC_BITS)))
      else $error("divide step overrun");

   // Requests are refused while a readout is in progress.
   a_busy_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !req_ready)
      else $error("request taken during readout");
endmodule

@@ tb/interval_overlap_rebinner_core_tb.sv @@
// Self-checking testbench for the interval overlap rebinner core.
module interval_overlap_rebinner_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import iorb_pkg::*;

   localparam int MAX_BINS  = 32;
   localparam int EDGE_BITS = 20;
   localparam int FRAC_BITS = 16;
   localparam int DRAIN     = 60;      // covers an accumulate or a readout's ring tail
   localparam int LIMIT     = 600000;
   localparam logic [EDGE_BITS-1:0] EDGE_TOP = {EDGE_BITS{1'b1}};

   typedef struct packed {
      logic [BIDX_W-1:0] bin_index;
      logic [ACC_W-1:0]  bin_total;
      logic              saturated;
      logic              width_error;
      logic              last;
   } bin_report_type;

   // Shadow copy of the rebinner: edges, accumulators, flags, bins in use.
   class rebin_scoreboard;
      logic [EDGE_BITS-1:0] edge_pos[MAX_BINS+1];
      logic [ACC_W-1:0]     bin_acc[MAX_BINS];
      bit                   bin_sat[MAX_BINS];
      bit                   width_err;
      int unsigned          bin_count;
      bin_report_type       pending_q[$];
      int                   errors;
      int                   results_seen;
      int                   readouts;

      function new();
         bin_count = MAX_BINS;
         width_err = 0;
         errors = 0;
         results_seen = 0;
         readouts = 0;
         foreach (bin_acc[b]) begin
            bin_acc[b] = '0;
            bin_sat[b] = 0;
         end
         foreach (edge_pos[e]) edge_pos[e] = '0;
      endfunction

      function void set_bins(logic [CFG_W-1:0] v);
         if (v < 1) bin_count = 1;
         else if (v > MAX_BINS) bin_count = MAX_BINS;
         else bin_count = v;
      endfunction

      function void spread(logic [63:0] lo, logic [63:0] hi, logic [63:0] content);
         logic [63:0] width, start, stop, frac, add, sum;
         if (hi <= lo) begin
            width_err = 1;
            return;
         end
         width = hi - lo;
         for (int b = 0; b < bin_count; b++) begin
            start = (edge_pos[b] > lo) ? edge_pos[b] : lo;
            stop  = (edge_pos[b+1] < hi) ? edge_pos[b+1] : hi;
            if (stop <= start) continue;
            frac = ((stop - start) << FRAC_BITS) / width;
            add  = (content * frac) >> FRAC_BITS;
            sum  = bin_acc[b] + add;
            if (sum >= ACC_MAX) begin
               sum = ACC_MAX;
               bin_sat[b] = 1;
            end
            bin_acc[b] = sum[ACC_W-1:0];
         end
      endfunction

      // Note an accepted request item and queue the bins it reads out.
      function void note_request(logic [CMD_W-1:0] cmd, logic [EIDX_W-1:0] idx,
                                 logic [EDGE_BITS-1:0] val, logic [EDGE_BITS-1:0] lo,
                                 logic [EDGE_BITS-1:0] hi, logic [CONTENT_W-1:0] content);
         bin_report_type r;
         case (cmd)
            CMD_LOAD_EDGE: begin
               if (idx <= MAX_BINS) edge_pos[idx] = val;
            end
            CMD_ACCUMULATE: spread(64'(lo), 64'(hi), 64'(content));
            CMD_READOUT: begin
               readouts++;
               for (int b = 0; b < bin_count; b++) begin
                  r.bin_index   = b[BIDX_W-1:0];
                  r.bin_total   = bin_acc[b];
                  r.saturated   = bin_sat[b];
                  r.width_error = width_err;
                  r.last        = (b + 1 == bin_count);
                  pending_q     = {pending_q, r};
               end
            end
            default: begin
               foreach (bin_acc[b]) begin
                  bin_acc[b] = '0;
                  bin_sat[b] = 0;
               end
            end
         endcase
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(bin_report_type got);
         bin_report_type want;
         results_seen++;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected result bin %0d", got.bin_index));
            return;
         end
         want = pending_q.pop_front();
         if (got.bin_index != want.bin_index)
            report($sformatf("bin_index %0d, want %0d", got.bin_index, want.bin_index));
         if (got.bin_total != want.bin_total)
            report($sformatf("bin %0d total %h, want %h", want.bin_index,
                             got.bin_total, want.bin_total));
         if (got.saturated != want.saturated)
            report($sformatf("bin %0d saturated %b, want %b", want.bin_index,
                             got.saturated, want.saturated));
         if (got.width_error != want.width_error)
            report($sformatf("bin %0d width_error %b, want %b", want.bin_index,
                             got.width_error, want.width_error));
         if (got.last != want.last)
            report($sformatf("bin %0d last %b, want %b", want.bin_index,
                             got.last, want.last));
      endtask
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_cmd = CMD_LOAD_EDGE;
   logic [EIDX_W-1:0]     req_edge_index = '0;
   logic [EDGE_BITS-1:0]  req_edge_value = '0;
   logic [EDGE_BITS-1:0]  req_src_low = '0;
   logic [EDGE_BITS-1:0]  req_src_high = '0;
   logic [CONTENT_W-1:0]  req_src_content = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 0;
   logic [BIDX_W-1:0]     rsp_bin_index;
   logic [ACC_W-1:0]      rsp_bin_total;
   logic                  rsp_saturated;
   logic                  rsp_width_error;
   logic                  rsp_last;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_bins_in_use = '0;

   int unsigned idle_pct  = 0;   // chance per cycle that the sender holds off
   int unsigned stall_pct = 0;   // chance per cycle that the receiver stalls
   int unsigned cycles    = 0;
   int unsigned items_sent = 0;
   rebin_scoreboard sb = new();

   interval_overlap_rebinner_core #(
      .MAX_BINS(MAX_BINS), .EDGE_BITS(EDGE_BITS), .FRAC_BITS(FRAC_BITS)
   ) u_top (.*);

   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("interval_overlap_rebinner_core_tb failed");
         $finish;
      end
   end

   // Receiver: stall at random, check every accepted result item.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_bin_index, rsp_bin_total, rsp_saturated,
                          rsp_width_error, rsp_last});
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Drive one request item; valid stays high until accepted, and is left high
   // so back-to-back items need no lowering in between.
   task automatic send(logic [CMD_W-1:0] cmd, logic [EIDX_W-1:0] idx,
                       logic [EDGE_BITS-1:0] val, logic [EDGE_BITS-1:0] lo,
                       logic [EDGE_BITS-1:0] hi, logic [CONTENT_W-1:0] content);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid       <= 1;
      req_cmd         <= cmd;
      req_edge_index  <= idx;
      req_edge_value  <= val;
      req_src_low     <= lo;
      req_src_high    <= hi;
      req_src_content <= content;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, idx, val, lo, hi, content);
      items_sent++;
   endtask

   // Hold off until every queued bin has come back, then let the core settle.
   task automatic drain();
      req_valid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_bins(logic [CFG_W-1:0] v);
      drain();
      csr_valid       <= 1;
      csr_bins_in_use <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.set_bins(v);
   endtask

   task automatic accumulate(logic [EDGE_BITS-1:0] lo, logic [EDGE_BITS-1:0] hi,
                             logic [CONTENT_W-1:0] content);
      send(CMD_ACCUMULATE, EIDX_W'($urandom), EDGE_BITS'($urandom), lo, hi, content);
   endtask

   task automatic command(logic [CMD_W-1:0] cmd);
      send(cmd, EIDX_W'($urandom), EDGE_BITS'($urandom), EDGE_BITS'($urandom),
           EDGE_BITS'($urandom), $urandom);
   endtask

   // Load every edge, 0 through MAX_BINS, in non-descending order with random spacing; never leaves one unwritten.
   task automatic load_ladder();
      logic [EDGE_BITS-1:0] pos;
      pos = EDGE_BITS'($urandom_range(0, 2000));
      for (int e = 0; e <= MAX_BINS; e++) begin
         send(CMD_LOAD_EDGE, EIDX_W'(e), pos, EDGE_BITS'($urandom),
              EDGE_BITS'($urandom), $urandom);
         pos = pos + EDGE_BITS'($urandom_range(0, 30000));
      end
   endtask

   // Well-formed accumulates inside the edge span, mixed with readouts, clears, edge loads and noise.
   task automatic random_items(int unsigned n);
      int unsigned pick;
      int unsigned stop_at;
      logic [EDGE_BITS-1:0] a, b;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         a = EDGE_BITS'($urandom_range(sb.edge_pos[0], sb.edge_pos[MAX_BINS]));
         b = EDGE_BITS'($urandom_range(sb.edge_pos[0], sb.edge_pos[MAX_BINS]));
         if (pick < 45) begin
            if (a == b) b = a + 1'b1;
            accumulate(a < b ? a : b, a < b ? b : a, $urandom);
         end else if (pick < 50) accumulate(a > b ? a : b, a > b ? b : a, $urandom);
         else if (pick < 65) command(CMD_READOUT);
         else if (pick < 70) command(CMD_CLEAR);
         else if (pick < 82)
            send(CMD_LOAD_EDGE, EIDX_W'($urandom_range(0, MAX_BINS)), a,
                 EDGE_BITS'($urandom), EDGE_BITS'($urandom), $urandom);
         else if (pick < 86)
            send(CMD_LOAD_EDGE, EIDX_W'($urandom_range(MAX_BINS + 1, 63)),
                 EDGE_BITS'($urandom), EDGE_BITS'($urandom), EDGE_BITS'($urandom),
                 $urandom);
         else if (pick < 87) load_ladder();
         else send(CMD_W'($urandom), EIDX_W'($urandom), EDGE_BITS'($urandom),
                   EDGE_BITS'($urandom), EDGE_BITS'($urandom), $urandom);
      end
      command(CMD_READOUT);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: edge ladder, extremes, bad widths, reversed bin, ignored loads.
      write_bins(6'd32);
      load_ladder();
      accumulate('0, EDGE_TOP, '1);
      accumulate(sb.edge_pos[0], sb.edge_pos[MAX_BINS], 32'h0001_0000);
      accumulate(sb.edge_pos[3], sb.edge_pos[4], '0);
      command(CMD_READOUT);
      accumulate(EDGE_BITS'(12345), EDGE_BITS'(12345), '1);   // zero width
      accumulate(EDGE_TOP, '0, '1);                          // negative width
      send(CMD_LOAD_EDGE, 6'd33, EDGE_TOP, '0, '0, '0);
      send(CMD_LOAD_EDGE, 6'd63, EDGE_TOP, '0, '0, '0);
      send(CMD_LOAD_EDGE, 6'd5, (sb.edge_pos[4] != '0) ? sb.edge_pos[4] - 1'b1 : '0,
           '0, '0, '0);                      // reversed target bin
      accumulate(sb.edge_pos[0], sb.edge_pos[MAX_BINS], '1);
      command(CMD_READOUT);
      command(CMD_CLEAR);
      command(CMD_READOUT);
      send(CMD_LOAD_EDGE, 6'd32, EDGE_TOP, '0, '0, '0);
      accumulate(sb.edge_pos[31], EDGE_TOP, 32'h8000_0000);
      command(CMD_READOUT);

      // Random phases: sweep idling, stalling and bins_in_use, extremes included.
      write_bins(6'd1);
      random_items(30);
      idle_pct = 88;
      write_bins(6'd63);
      random_items(30);
      idle_pct = 0; stall_pct = 88;
      write_bins(6'd0);
      random_items(30);
      idle_pct = 37; stall_pct = 37;
      write_bins(CFG_W'($urandom_range(2, 31)));
      random_items(30);
      idle_pct = 0; stall_pct = 0;
      write_bins(CFG_W'($urandom_range(0, 63)));
      random_items(30);

      drain();
      $display("covered %0d request items, %0d readouts, %0d bin results checked",
               items_sent, sb.readouts, sb.results_seen);
      if (sb.errors == 0)
         $display("interval_overlap_rebinner_core_tb passed");
      else
         $display("interval_overlap_rebinner_core_tb failed");
      $finish;
   end
endmodule
